### rtl/core/lirs_pkg.sv
package lirs_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS     = 16;
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_BITS      = PHASE_FRAC_BITS + 5;
  localparam int STEP_BITS       = 20;
  localparam int CHAN_BITS       = 2;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = STEP_BITS;

  // Interpolation arithmetic widths
  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + PHASE_FRAC_BITS + 1;

  // Run length limit per input frame
  localparam int MAX_OUT  = 64;
  localparam int CNT_BITS = $clog2(MAX_OUT);

  localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << PHASE_FRAC_BITS;

  // Register reset values
  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(65536);
  localparam logic [CHAN_BITS-1:0] CHAN_RESET = CHAN_BITS'(2);
  localparam logic [CHAN_BITS-1:0] CHAN_MONO  = CHAN_BITS'(1);

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP    = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = CFG_INDEX_BITS'(1);

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic store_frame;
    logic skip_frame;
    logic mul_left;
    logic mul_right;
    logic emit;
  } lirs_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic store_only;
    logic phase_ge_one;
    logic last;
    logic out_busy;
    logic mono;
  } lirs_status_t;

endpackage

### rtl/core/lirs_frame_if.sv
interface lirs_frame_if
  import lirs_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;
  logic                          block_start;

  modport source (output valid, sample_left, sample_right, block_start, input ready);
  modport sink   (input valid, sample_left, sample_right, block_start, output ready);
endinterface

### rtl/core/lirs_result_if.sv
interface lirs_result_if
  import lirs_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          last_in_run;

  modport source (output valid, out_left, out_right, last_in_run, input ready);
  modport sink   (input valid, out_left, out_right, last_in_run, output ready);
endinterface

### rtl/core/lirs_cfg_if.sv
interface lirs_cfg_if
  import lirs_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/lirs_ctrl.sv
module lirs_ctrl
  import lirs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  lirs_status_t status,
  output lirs_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MUL_L = 5'b00100,
    S_MUL_R = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (status.store_only) begin
          cmd.store_frame = 1'b1;
          state_next      = S_IDLE;
        end else if (status.phase_ge_one) begin
          cmd.skip_frame = 1'b1;
          state_next     = S_IDLE;
        end else begin
          state_next = S_MUL_L;
        end
      end
      S_MUL_L: begin
        cmd.mul_left = 1'b1;
        state_next   = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_right = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        // hold the finished frame until the output register frees up
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = status.last ? S_IDLE : S_MUL_L;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/core/lirs_datapath.sv
module lirs_datapath
  import lirs_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic signed [SAMPLE_BITS-1:0] sample_left,
  input  logic signed [SAMPLE_BITS-1:0] sample_right,
  input  logic                          block_start,
  input  lirs_cmd_t                     cmd,
  output lirs_status_t                  status,
  lirs_cfg_if.sink                      cfg,
  lirs_result_if.source                 results
);

  // Configuration
  logic [STEP_BITS-1:0] phase_step;
  logic [CHAN_BITS-1:0] channel_count;

  // Frame state
  logic signed [SAMPLE_BITS-1:0] prev_left;
  logic signed [SAMPLE_BITS-1:0] prev_right;
  logic [PHASE_BITS-1:0]         phase;
  logic                          have_prev;
  logic [CNT_BITS-1:0]           count;
  logic                          out_valid;

  // Working registers
  logic signed [SAMPLE_BITS-1:0] new_left;
  logic signed [SAMPLE_BITS-1:0] new_right;
  logic signed [DIFF_BITS-1:0]   diff_left;
  logic signed [DIFF_BITS-1:0]   diff_right;
  logic                          block_flag;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [SAMPLE_BITS-1:0] sum_left;
  logic signed [SAMPLE_BITS-1:0] res_left;
  logic signed [SAMPLE_BITS-1:0] res_right;
  logic                          res_last;

  logic                          mono;
  logic signed [SAMPLE_BITS-1:0] in_right;
  logic signed [PHASE_FRAC_BITS:0] frac;
  logic signed [PROD_BITS-1:0]   prod_shift;
  logic signed [SAMPLE_BITS-1:0] interp;
  logic [PHASE_BITS-1:0]         phase_sum;
  logic                          sum_ge_one;
  logic [PHASE_BITS-1:0]         phase_final;

  assign mono     = (channel_count == CHAN_MONO);
  assign in_right = mono ? '0 : sample_right;
  assign cfg.ready = 1'b1;

  // Interpolation: floor shift of the product, added to the previous sample
  assign frac       = $signed({1'b0, phase[PHASE_FRAC_BITS-1:0]});
  assign prod_shift = prod >>> PHASE_FRAC_BITS;
  assign interp     = SAMPLE_BITS'(prod_shift);

  // Phase advance and end of run
  assign phase_sum   = phase + PHASE_BITS'(phase_step);
  assign sum_ge_one  = (phase_sum >= PHASE_ONE);
  assign phase_final = sum_ge_one ? (phase_sum - PHASE_ONE) : '0;

  assign status.store_only   = block_flag || !have_prev;
  assign status.phase_ge_one = (phase >= PHASE_ONE);
  assign status.last         = sum_ge_one || (count == CNT_BITS'(MAX_OUT - 1));
  assign status.out_busy     = out_valid && !results.ready;
  assign status.mono         = mono;

  assign results.valid       = out_valid;
  assign results.out_left    = res_left;
  assign results.out_right   = res_right;
  assign results.last_in_run = res_last;

  // Control state, configuration and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= STEP_RESET;
      channel_count <= CHAN_RESET;
      prev_left     <= '0;
      prev_right    <= '0;
      phase         <= '0;
      have_prev     <= 1'b0;
      count         <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_PHASE_STEP:    phase_step    <= cfg.data[STEP_BITS-1:0];
          REG_CHANNEL_COUNT: channel_count <= cfg.data[CHAN_BITS-1:0];
          default: begin
          end
        endcase
      end
      // a new result refills the register in the cycle the old one leaves
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        count <= '0;
      end
      if (cmd.store_frame) begin
        prev_left  <= new_left;
        prev_right <= new_right;
        phase      <= '0;
        have_prev  <= 1'b1;
      end
      if (cmd.skip_frame) begin
        prev_left  <= new_left;
        prev_right <= new_right;
        phase      <= phase - PHASE_ONE;
      end
      if (cmd.emit) begin
        count     <= count + CNT_BITS'(1);
        if (status.last) begin
          phase      <= phase_final;
          prev_left  <= new_left;
          prev_right <= new_right;
        end else begin
          phase <= phase_sum;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      new_left   <= sample_left;
      new_right  <= in_right;
      diff_left  <= DIFF_BITS'(sample_left) - DIFF_BITS'(prev_left);
      diff_right <= DIFF_BITS'(in_right) - DIFF_BITS'(prev_right);
      block_flag <= block_start;
    end
    if (cmd.mul_left) begin
      prod <= diff_left * frac;
    end
    if (cmd.mul_right) begin
      sum_left <= prev_left + interp;
      prod     <= diff_right * frac;
    end
    if (cmd.emit) begin
      res_left  <= sum_left;
      res_right <= mono ? '0 : (prev_right + interp);
      res_last  <= status.last;
    end
  end

endmodule

### rtl/core/linear_interp_resampler.sv
// Channel   Dir  Handshake      Payload
// samples   in   valid/ready    sample_left[16] sample_right[16] block_start
// results   out  valid/ready    out_left[16] out_right[16] last_in_run
// cfg       in   valid/ready    index[2] data[20] (0 phase_step, 1 channel_count)
//
// One frame at a time: a frame that only stores (block start, first frame,
// phase at or above one) gives no result; one that gives n results runs a
// left and a right multiply per result on the one multiplier they share.
// rst is synchronous, active high; it clears the stored frame and phase and
// loads phase_step = 0x10000, channel_count = 2. cfg is always ready.
// A stalled result holds in the output register; the run pauses until it moves.
module linear_interp_resampler
  import lirs_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  lirs_frame_if.sink     samples,
  lirs_result_if.source  results,
  lirs_cfg_if.sink       cfg
);

  lirs_cmd_t    cmd;
  lirs_status_t status;
  logic         in_ready;

  assign samples.ready = in_ready;

  lirs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lirs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .sample_left  (samples.sample_left),
    .sample_right (samples.sample_right),
    .block_start  (samples.block_start),
    .cmd          (cmd),
    .status       (status),
    .cfg          (cfg),
    .results      (results)
  );

  // One frame in flight: no transfer right after an accepted frame
  assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("frame accepted while another is in work");

  // A new result never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !status.out_busy)
    else $error("result register overwritten");

  // Mono runs give a zero right channel
  assert property (@(posedge clk) disable iff (rst)
    results.valid && status.mono && $past(status.mono) |-> results.out_right == '0)
    else $error("nonzero right sample in mono");

endmodule
